/* hdl/dna_key_set_insert_find_top_assert.svh */
// assertion macros for the key-set store
`ifndef DNA_KEY_SET_INSERT_FIND_TOP_ASSERT_SVH
`define DNA_KEY_SET_INSERT_FIND_TOP_ASSERT_SVH

// antecedent holds, consequent in the same cycle
`define DKS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds, consequent in the following cycle
`define DKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/dks_pkg.sv */
package dks_pkg;

   localparam int NUM_BUCKETS = 4;
   localparam int BUCKET_W    = 2;
   localparam int SYM_W       = 2;
   localparam int KEY_W       = 24;
   localparam int LEN_W       = 4;
   localparam int NUM_SYMS    = KEY_W / SYM_W;
   localparam int MAX_SYMBOLS = 12;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_FIND   = 1'b1;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [KEY_W-1:0] syms;
   } entry_type;

   typedef struct packed {
      logic load;
      logic write;
      logic scan_clear;
      logic scan_issue;
   } dks_cmd_type;

   typedef struct packed {
      logic is_find;
      logic key_empty;
      logic full;
      logic issue_done;
      logic rd_vld;
      logic match;
   } dks_status_type;

endpackage

/* hdl/dks_ctrl.sv */
module dks_ctrl
   import dks_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  dks_status_type status,
   output dks_cmd_type    cmd,
   output logic           busy,
   output logic           rsp_valid,
   output logic           rsp_found
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_found_ff;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_DECIDE: begin
            cmd.write      = !status.is_find && !status.key_empty && !status.full;
            cmd.scan_clear = status.is_find;
         end
         ST_SCAN: begin
            cmd.scan_issue = !status.issue_done;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_found_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (!status.is_find) begin
                  state_ff <= ST_IDLE;
               end else if (status.key_empty) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (status.match) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else if (status.issue_done && !status.rd_vld) begin
                  // last entry compared without a hit
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* hdl/dks_datapath.sv */
module dks_datapath
   import dks_pkg::*;
#(
   parameter int BUCKET_DEPTH = 1024
)
(
   input  logic             clock,
   input  logic             reset,
   input  dks_cmd_type      cmd,
   input  logic             req_action,
   input  logic [KEY_W-1:0] req_key_symbols,
   input  logic [LEN_W-1:0] req_key_length,
   output dks_status_type   status
);

   localparam int IDX_W     = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int CNT_W     = $clog2(BUCKET_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_BUCKETS * (2 ** IDX_W);

   entry_type             mem [MEM_DEPTH];
   entry_type             key_ff;
   entry_type             key_in;
   logic                  action_ff;
   logic [BUCKET_W-1:0]   bucket_ff;
   logic [CNT_W-1:0]      counts_ff [NUM_BUCKETS];
   logic [CNT_W-1:0]      cnt_sel;
   logic [CNT_W-1:0]      idx_ff;
   entry_type             rd_data_ff;
   logic                  rd_vld_ff;
   logic [LEN_W-1:0]      len_eff;

   // saturate the length, then clear symbols at and above it
   always_comb begin
      len_eff = (req_key_length > LEN_W'(MAX_SYMBOLS)) ? LEN_W'(MAX_SYMBOLS)
                                                       : req_key_length;
      key_in.len  = len_eff;
      key_in.syms = '0;
      for (int i = 0; i < NUM_SYMS; i++) begin
         if (LEN_W'(i) < len_eff) begin
            key_in.syms[i*SYM_W +: SYM_W] = req_key_symbols[i*SYM_W +: SYM_W];
         end
      end
   end

   assign cnt_sel = counts_ff[bucket_ff];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff    <= key_in;
         action_ff <= req_action;
         bucket_ff <= req_key_symbols[BUCKET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            counts_ff[b] <= '0;
         end
      end else if (cmd.write) begin
         counts_ff[bucket_ff] <= cnt_sel + CNT_W'(1);
      end
   end

   // entry store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[{bucket_ff, cnt_sel[IDX_W-1:0]}] <= key_ff;
      end
      if (cmd.scan_issue) begin
         rd_data_ff <= mem[{bucket_ff, idx_ff[IDX_W-1:0]}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else if (cmd.scan_clear) begin
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_issue;
         if (cmd.scan_issue) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      status.is_find    = (action_ff == ACTION_FIND);
      status.key_empty  = (key_ff.len == '0);
      status.full       = (cnt_sel == CNT_W'(BUCKET_DEPTH));
      status.issue_done = (idx_ff == cnt_sel);
      status.rd_vld     = rd_vld_ff;
      status.match      = rd_vld_ff && (rd_data_ff == key_ff);
   end

endmodule

/* hdl/dna_key_set_insert_find_top.sv */
// insert: busy only while in the decide state after the accepting edge, no result
// find of a bucket holding n keys: result strobe once the scan has compared all n entries
// at most (earlier on a hit), next start taken once busy is low; worst n = BUCKET_DEPTH
// the scan reads one entry a cycle through the single read port of the entry store
// synchronous reset empties all four buckets at once; the store itself is not cleared
// the receiver cannot stall: each result is one strobe cycle
`include "dna_key_set_insert_find_top_assert.svh"

module dna_key_set_insert_find_top
   import dks_pkg::*;
#(
   parameter int BUCKET_DEPTH = 1024
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_action,
   input  logic [KEY_W-1:0] req_key_symbols,
   input  logic [LEN_W-1:0] req_key_length,
   output logic             rsp_valid,
   output logic             rsp_found
);

   dks_cmd_type    cmd;
   dks_status_type status;

   dks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_found (rsp_found)
   );

   dks_datapath #(
      .BUCKET_DEPTH (BUCKET_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_action      (req_action),
      .req_key_symbols (req_key_symbols),
      .req_key_length  (req_key_length),
      .status          (status)
   );

   `DKS_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `DKS_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "double strobe")
   `DKS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "not busy after transfer")
   `DKS_ASSERT_SAME(a_no_full_write, clock, reset, cmd.write, !status.full, "write to full bucket")

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import dks_pkg::*;

   localparam int DEPTH       = 1024;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_KEYS = 520;
   localparam int CALM_KEYS   = 40;

   typedef enum logic [1:0] {
      SYM_A = 2'd0,
      SYM_C = 2'd1,
      SYM_G = 2'd2,
      SYM_T = 2'd3
   } nucleotide_type;

   typedef struct {
      logic [KEY_W-1:0] syms;
      logic [LEN_W-1:0] len;
   } key_rec_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic             req_action = ACTION_INSERT;
   logic [KEY_W-1:0] req_key_symbols = '0;
   logic [LEN_W-1:0] req_key_length = '0;
   logic             rsp_valid;
   logic             rsp_found;

   // shadow of the four buckets
   entry_type   shadow_entries [NUM_BUCKETS][DEPTH];
   int unsigned shadow_fill [NUM_BUCKETS];
   logic        found_expected [$];
   key_rec_type known_keys [$];

   bit idle_on    = 1'b1;
   int idle_odds  = 4;
   int n_errors   = 0;
   int n_stored   = 0;
   int n_finds    = 0;
   int n_hits     = 0;
   int stall_cycles = 0;

   dna_key_set_insert_find_top #(
      .BUCKET_DEPTH(DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_key_symbols (req_key_symbols),
      .req_key_length  (req_key_length),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      n_errors++;
   endtask

   function automatic logic [LEN_W-1:0] effective_len(input logic [LEN_W-1:0] len);
      return (len > MAX_SYMBOLS) ? LEN_W'(MAX_SYMBOLS) : len;
   endfunction

   function automatic logic [KEY_W-1:0] symbol_mask(input logic [LEN_W-1:0] len);
      logic [KEY_W-1:0] m;
      int i;
      m = '0;
      for (i = 0; i < NUM_SYMS; i++) begin
         if (i < effective_len(len)) begin
            m[i*SYM_W +: SYM_W] = '1;
         end
      end
      return m;
   endfunction

   function automatic entry_type canon_key(input logic [KEY_W-1:0] syms,
                                           input logic [LEN_W-1:0] len);
      entry_type e;
      e.len  = effective_len(len);
      e.syms = syms & symbol_mask(len);
      return e;
   endfunction

   // apply one accepted command to the shadow; a find queues its answer
   task automatic update_key_shadow(input logic act, input logic [KEY_W-1:0] syms,
                                    input logic [LEN_W-1:0] len);
      entry_type   k;
      int unsigned b;
      logic        hit;
      int          j;
      k   = canon_key(syms, len);
      b   = {30'd0, syms[SYM_W-1:0]};
      hit = 1'b0;
      if (act == ACTION_INSERT) begin
         if (k.len != 0) begin
            known_keys.push_back('{syms, len});
            if (shadow_fill[b] < DEPTH) begin
               shadow_entries[b][shadow_fill[b]] = k;
               shadow_fill[b]++;
               n_stored++;
            end
         end
      end else begin
         if (k.len != 0) begin
            for (j = 0; j < shadow_fill[b]; j++) begin
               if (shadow_entries[b][j] == k) begin
                  hit = 1'b1;
               end
            end
         end
         found_expected.push_back(hit);
         n_finds++;
      end
   endtask

   // start stays high across back-to-back transfers
   task automatic issue_command(input logic act, input logic [KEY_W-1:0] syms,
                                input logic [LEN_W-1:0] len);
      if (idle_on && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      start           <= 1'b1;
      req_action      <= act;
      req_key_symbols <= syms;
      req_key_length  <= len;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      update_key_shadow(act, syms, len);
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      while (found_expected.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_keys();
      issue_command(ACTION_FIND,   24'h000000, 4'd1);
      issue_command(ACTION_INSERT, 24'h000000, 4'd1);
      issue_command(ACTION_FIND,   24'h000000, 4'd1);
      // garbage above the length must be ignored
      issue_command(ACTION_FIND,   24'hFFFFFC, 4'd1);
      issue_command(ACTION_FIND,   24'h000000, 4'd2);
      issue_command(ACTION_INSERT, 24'hFFFFFF, 4'd12);
      // lengths above twelve saturate
      issue_command(ACTION_FIND,   24'hFFFFFF, 4'd15);
      issue_command(ACTION_INSERT, 24'h123456, 4'd15);
      issue_command(ACTION_FIND,   24'h123456, 4'd12);
      // empty keys: insert ignored, find misses
      issue_command(ACTION_INSERT, 24'hABCDEF, 4'd0);
      issue_command(ACTION_FIND,   24'hABCDEF, 4'd0);
      issue_command(ACTION_FIND,   24'hABCDEF, 4'd12);
      // duplicates are kept
      issue_command(ACTION_INSERT, 24'h000005, 4'd2);
      issue_command(ACTION_INSERT, 24'h000005, 4'd2);
      issue_command(ACTION_FIND,   24'hFF0005, 4'd2);
      issue_command(ACTION_INSERT, 24'h00000A, 4'd2);
      issue_command(ACTION_FIND,   24'h00000A, 4'd3);
      issue_command(ACTION_FIND,   24'h00000A, 4'd2);
      issue_command(ACTION_INSERT, 24'h555555, 4'd13);
      issue_command(ACTION_FIND,   24'h555555, 4'd14);
      issue_command(ACTION_FIND,   {22'd0, SYM_G}, 4'd1);
      issue_command(ACTION_INSERT, 24'hFFFFFF, 4'd8);
      issue_command(ACTION_FIND,   24'h00FFFF, 4'd8);
   endtask

   // mostly inserts of short keys and finds of keys seen before
   task automatic test_random_traffic(input int count);
      int               n;
      int unsigned      pick;
      key_rec_type      rec;
      logic [KEY_W-1:0] syms;
      logic [KEY_W-1:0] m;
      logic [LEN_W-1:0] len;
      for (n = 0; n < count; n++) begin
         if (n % 64 == 0) begin
            idle_odds = $urandom_range(0, 6);
         end
         pick = $urandom_range(0, 99);
         syms = KEY_W'($urandom);
         len  = ($urandom_range(0, 9) < 6) ? LEN_W'($urandom_range(1, 3))
                                          : LEN_W'($urandom_range(0, 15));
         if (pick < 40 || known_keys.size() == 0) begin
            issue_command(ACTION_INSERT, syms, len);
         end else if (pick < 85) begin
            rec  = known_keys[$urandom_range(0, known_keys.size() - 1)];
            m    = symbol_mask(rec.len);
            syms = (rec.syms & m) | (syms & ~m);
            len  = rec.len;
            if (pick >= 75) begin
               // neighbouring length, usually a miss
               len = (len <= 1) ? 4'd2
                                : ((pick & 1) ? LEN_W'(len - 4'd1) : LEN_W'(len + 4'd1));
            end else if (len >= MAX_SYMBOLS) begin
               len = LEN_W'($urandom_range(MAX_SYMBOLS, 15));
            end
            issue_command(ACTION_FIND, syms, len);
         end else begin
            issue_command(ACTION_FIND, syms, len);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (found_expected.size() == 0) begin
            report_mismatch("result strobe with no find outstanding");
         end else begin
            if (rsp_found !== found_expected[0]) begin
               report_mismatch($sformatf("found is %b, expected %b",
                                         rsp_found, found_expected[0]));
            end
            if (rsp_found === 1'b1) begin
               n_hits++;
            end
            void'(found_expected.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      foreach (shadow_fill[b]) shadow_fill[b] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_keys();
      test_random_traffic(RANDOM_KEYS / 2);
      hold_until_drained();
      test_random_traffic(RANDOM_KEYS / 2);
      idle_on = 1'b0;
      test_random_traffic(CALM_KEYS);

      hold_until_drained();
      repeat (DEPTH + 8) @(posedge clock);
      if (found_expected.size() != 0) begin
         report_mismatch($sformatf("%0d finds never answered", found_expected.size()));
      end
      $display("covered %0d keys stored across the four buckets, incl. duplicates",
               n_stored);
      $display("covered %0d finds, %0d of them hits; %0d mismatches",
               n_finds, n_hits, n_errors);
      if (n_errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
